FILE: rtl/core/cpqw_pkg.sv
package cpqw_pkg;

   localparam int MAX_SIDE = 4096;

   localparam int SIZE_W = 13;
   localparam int CTRL_W = 12;
   localparam int POS_W  = 12;
   localparam int HALF_W = 12;
   localparam int OFF_W  = 11;
   localparam int CRD_W  = 14;
   localparam int PAB_W  = 15;
   localparam int MAG_W  = 12;
   localparam int MAGB_W = 13;
   localparam int PA_W   = MAG_W + OFF_W;
   localparam int PABI_W = MAGB_W + OFF_W;
   localparam int DEN_W  = 2 * HALF_W;
   localparam int NUM_W  = PABI_W + OFF_W + 1;
   localparam int QB     = 13;
   localparam int Q_W    = QB + 1;
   localparam int SUM_W  = CRD_W + 3;
   localparam int ST_W   = 2;

   localparam logic [1:0] CSR_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_CONTROLX = 2'd2;
   localparam logic [1:0] CSR_CONTROLY = 2'd3;

   localparam logic [ST_W-1:0] STAT_FETCH = 2'd0;
   localparam logic [ST_W-1:0] STAT_FILL  = 2'd1;
   localparam logic [ST_W-1:0] STAT_NONE  = 2'd2;

   typedef logic [NUM_W-1:0]        num_type;
   typedef logic [DEN_W-1:0]        den_type;
   typedef logic signed [Q_W-1:0]   quo_type;
   typedef logic signed [CRD_W-1:0] crd_type;
   typedef logic signed [PAB_W-1:0] pab_type;

   typedef struct packed {
      logic              none;
      crd_type           p1;
      logic [SIZE_W-1:0] lim;
   } side_type;

endpackage

FILE: rtl/core/cpqw_div.sv
module cpqw_div (
   input  logic              clock,
   input  logic              en,
   input  cpqw_pkg::num_type num,
   input  cpqw_pkg::den_type den,
   input  logic              neg,
   output cpqw_pkg::quo_type quo
);
   import cpqw_pkg::*;

   localparam int CMP_W = DEN_W + QB;

   num_type        rem_ff [QB];
   den_type        den_ff [QB];
   logic [QB-1:0]  q_ff   [QB];
   logic           neg_ff [QB];

   num_type        rem_src [QB];
   den_type        den_src [QB];
   logic [QB-1:0]  q_src   [QB];
   logic           neg_src [QB];
   num_type        rem_in  [QB];
   logic [QB-1:0]  q_in    [QB];

   always_comb begin
      logic [CMP_W-1:0] shifted;
      logic [CMP_W-1:0] rem_x;
      rem_src[0] = num;
      den_src[0] = den;
      q_src[0]   = '0;
      neg_src[0] = neg;
      for (int k = 1; k < QB; k++) begin
         rem_src[k] = rem_ff[k-1];
         den_src[k] = den_ff[k-1];
         q_src[k]   = q_ff[k-1];
         neg_src[k] = neg_ff[k-1];
      end
      for (int k = 0; k < QB; k++) begin
         shifted = CMP_W'(den_src[k]) << (QB - 1 - k);
         rem_x   = CMP_W'(rem_src[k]);
         if (rem_x >= shifted) begin
            rem_in[k] = NUM_W'(rem_x - shifted);
            q_in[k]   = {q_src[k][QB-2:0], 1'b1};
         end else begin
            rem_in[k] = rem_src[k];
            q_in[k]   = {q_src[k][QB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QB; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_src[k];
            q_ff[k]   <= q_in[k];
            neg_ff[k] <= neg_src[k];
         end
      end
   end

   assign quo = neg_ff[QB-1] ? -quo_type'({1'b0, q_ff[QB-1]})
                             : quo_type'({1'b0, q_ff[QB-1]});

endmodule

FILE: rtl/core/control_point_quad_warp_addr.sv
// Address generator for a control-point quadrant warp.
// The req channel carries one output pixel position (row, column) per beat;
// the rsp channel returns one beat per request with the source column and
// row to fetch and a status: fetch, fill, or not covered.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. Image size and control point are set through the csr write
// port and must only change while no request is in flight.
// One request can be taken every cycle while the pipeline is not held by
// rsp_stall. A request passes three setup stages, then each of the three
// bilinear terms per coordinate is divided by a restoring divider pipelined
// one quotient bit per stage (13 stages), then the response register.
// When the receiver stalls with a response waiting, the whole pipeline
// holds and req_stall is raised, so nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads the default 256 by 256
// image with the control point at (128, 128).
module control_point_quad_warp_addr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cpqw_pkg::POS_W-1:0]    req_out_row,
   input  logic [cpqw_pkg::POS_W-1:0]    req_out_col,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [cpqw_pkg::CRD_W-1:0] rsp_src_x,
   output logic signed [cpqw_pkg::CRD_W-1:0] rsp_src_y,
   output logic [cpqw_pkg::ST_W-1:0]     rsp_status,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_index,
   input  logic [cpqw_pkg::SIZE_W-1:0]   csr_wdata
);
   import cpqw_pkg::*;

   typedef struct packed {
      logic              none;
      logic [HALF_W-1:0] cw;
      logic [HALF_W-1:0] rh;
      logic [OFF_W-1:0]  i;
      logic [OFF_W-1:0]  j;
      crd_type           x1, xa, xb;
      pab_type           xab;
      crd_type           y1, ya, yb;
      pab_type           yab;
      logic [SIZE_W-1:0] w, h;
   } s1_type;

   typedef struct packed {
      logic [OFF_W-1:0]  j;
      logic [PA_W-1:0]   xa, xb, ya, yb;
      logic [PABI_W-1:0] xabi, yabi;
      logic [3:0]        nx, ny;
      den_type           cwrh;
      logic [HALF_W-1:0] cw, rh;
      side_type          sx, sy;
   } s2_type;

   typedef struct packed {
      num_type           xa, xb, xab, ya, yb, yab;
      logic [3:0]        nx, ny;
      den_type           cwrh;
      logic [HALF_W-1:0] cw, rh;
      side_type          sx, sy;
   } s3_type;

   logic [SIZE_W-1:0] cfg_w_ff, cfg_h_ff;
   logic [CTRL_W-1:0] cfg_cx_ff, cfg_cy_ff;

   logic   s1_v_ff, s2_v_ff, s3_v_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   logic     dv_ff [QB];
   side_type dsx_ff [QB];
   side_type dsy_ff [QB];

   logic                    rsp_valid_ff;
   logic signed [CRD_W-1:0] rsp_x_ff, rsp_y_ff, rsp_x_in, rsp_y_in;
   logic [ST_W-1:0]         rsp_st_ff, rsp_st_in;

   logic    advance;
   quo_type qxa, qxb, qxab, qya, qyb, qyab;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff  <= SIZE_W'(256);
         cfg_h_ff  <= SIZE_W'(256);
         cfg_cx_ff <= CTRL_W'(128);
         cfg_cy_ff <= CTRL_W'(128);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WIDTH:    cfg_w_ff  <= csr_wdata;
            CSR_HEIGHT:   cfg_h_ff  <= csr_wdata;
            CSR_CONTROLX: cfg_cx_ff <= csr_wdata[CTRL_W-1:0];
            CSR_CONTROLY: cfg_cy_ff <= csr_wdata[CTRL_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      logic [SIZE_W-1:0] w, h;
      logic [HALF_W-1:0] cw, rh;
      logic              right, lower;
      logic [POS_W-1:0]  jj, ii;
      crd_type           cws, rhs, wm1, hm1, cx, cy;
      crd_type           x1, x2, x3, x4, y1, y2, y3, y4;
      w   = (cfg_w_ff > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : cfg_w_ff;
      h   = (cfg_h_ff > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : cfg_h_ff;
      cw  = w[SIZE_W-1:1];
      rh  = h[SIZE_W-1:1];
      right = req_out_col >= cw;
      lower = req_out_row >= rh;
      jj  = right ? req_out_col - cw : req_out_col;
      ii  = lower ? req_out_row - rh : req_out_row;
      cws = crd_type'({2'b00, cw});
      rhs = crd_type'({2'b00, rh});
      wm1 = crd_type'({1'b0, w}) - crd_type'(1);
      hm1 = crd_type'({1'b0, h}) - crd_type'(1);
      cx  = crd_type'({2'b00, cfg_cx_ff});
      cy  = crd_type'({2'b00, cfg_cy_ff});
      if (!right && !lower) begin
         x1 = '0;  x2 = cws; x3 = cx;  x4 = '0;
         y1 = '0;  y2 = '0;  y3 = cy;  y4 = rhs;
      end else if (right && !lower) begin
         x1 = cws; x2 = wm1; x3 = wm1; x4 = cx;
         y1 = '0;  y2 = '0;  y3 = rhs; y4 = cy;
      end else if (right && lower) begin
         x1 = cx;  x2 = wm1; x3 = wm1; x4 = cws;
         y1 = cy;  y2 = rhs; y3 = hm1; y4 = hm1;
      end else begin
         x1 = '0;  x2 = cx;  x3 = cws; x4 = '0;
         y1 = rhs; y2 = cy;  y3 = hm1; y4 = hm1;
      end
      s1_in.none = (cw == '0) || (rh == '0) ||
                   ({1'b0, req_out_col} >= {cw, 1'b0}) ||
                   ({1'b0, req_out_row} >= {rh, 1'b0});
      s1_in.cw  = cw;
      s1_in.rh  = rh;
      s1_in.i   = ii[OFF_W-1:0];
      s1_in.j   = jj[OFF_W-1:0];
      s1_in.x1  = x1;
      s1_in.xa  = x2 - x1;
      s1_in.xb  = x4 - x1;
      s1_in.xab = pab_type'(x1) - pab_type'(x2) + pab_type'(x3) - pab_type'(x4);
      s1_in.y1  = y1;
      s1_in.ya  = y2 - y1;
      s1_in.yb  = y4 - y1;
      s1_in.yab = pab_type'(y1) - pab_type'(y2) + pab_type'(y3) - pab_type'(y4);
      s1_in.w   = w;
      s1_in.h   = h;
   end

   function automatic logic [MAG_W-1:0] mag_crd(input crd_type v);
      crd_type a;
      a = v[CRD_W-1] ? -v : v;
      return a[MAG_W-1:0];
   endfunction

   function automatic logic [MAGB_W-1:0] mag_pab(input pab_type v);
      pab_type a;
      a = v[PAB_W-1] ? -v : v;
      return a[MAGB_W-1:0];
   endfunction

   always_comb begin
      s2_in.j    = s1_ff.j;
      s2_in.xa   = PA_W'(mag_crd(s1_ff.xa)) * PA_W'(s1_ff.j);
      s2_in.xb   = PA_W'(mag_crd(s1_ff.xb)) * PA_W'(s1_ff.i);
      s2_in.ya   = PA_W'(mag_crd(s1_ff.ya)) * PA_W'(s1_ff.j);
      s2_in.yb   = PA_W'(mag_crd(s1_ff.yb)) * PA_W'(s1_ff.i);
      s2_in.xabi = PABI_W'(mag_pab(s1_ff.xab)) * PABI_W'(s1_ff.i);
      s2_in.yabi = PABI_W'(mag_pab(s1_ff.yab)) * PABI_W'(s1_ff.i);
      s2_in.nx   = {1'b0, s1_ff.xa[CRD_W-1], s1_ff.xb[CRD_W-1], s1_ff.xab[PAB_W-1]};
      s2_in.ny   = {1'b0, s1_ff.ya[CRD_W-1], s1_ff.yb[CRD_W-1], s1_ff.yab[PAB_W-1]};
      s2_in.cwrh = DEN_W'(s1_ff.cw) * DEN_W'(s1_ff.rh);
      s2_in.cw   = s1_ff.cw;
      s2_in.rh   = s1_ff.rh;
      s2_in.sx   = '{none: s1_ff.none, p1: s1_ff.x1, lim: s1_ff.w};
      s2_in.sy   = '{none: s1_ff.none, p1: s1_ff.y1, lim: s1_ff.h};
   end

   always_comb begin
      s3_in.xa   = NUM_W'(s2_ff.xa);
      s3_in.xb   = NUM_W'(s2_ff.xb);
      s3_in.ya   = NUM_W'(s2_ff.ya);
      s3_in.yb   = NUM_W'(s2_ff.yb);
      s3_in.xab  = NUM_W'(s2_ff.xabi) * NUM_W'(s2_ff.j);
      s3_in.yab  = NUM_W'(s2_ff.yabi) * NUM_W'(s2_ff.j);
      s3_in.nx   = s2_ff.nx;
      s3_in.ny   = s2_ff.ny;
      s3_in.cwrh = s2_ff.cwrh;
      s3_in.cw   = s2_ff.cw;
      s3_in.rh   = s2_ff.rh;
      s3_in.sx   = s2_ff.sx;
      s3_in.sy   = s2_ff.sy;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         dsx_ff[0] <= s3_ff.sx;
         dsy_ff[0] <= s3_ff.sy;
         for (int k = 1; k < QB; k++) begin
            dsx_ff[k] <= dsx_ff[k-1];
            dsy_ff[k] <= dsy_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         for (int k = 0; k < QB; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         s1_v_ff  <= req_valid;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         dv_ff[0] <= s3_v_ff;
         for (int k = 1; k < QB; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end
   end

   cpqw_div u_div_xa (.clock(clock), .en(advance), .num(s3_ff.xa),
      .den(DEN_W'(s3_ff.cw)), .neg(s3_ff.nx[2]), .quo(qxa));
   cpqw_div u_div_xb (.clock(clock), .en(advance), .num(s3_ff.xb),
      .den(DEN_W'(s3_ff.rh)), .neg(s3_ff.nx[1]), .quo(qxb));
   cpqw_div u_div_xab (.clock(clock), .en(advance), .num(s3_ff.xab),
      .den(s3_ff.cwrh), .neg(s3_ff.nx[0]), .quo(qxab));
   cpqw_div u_div_ya (.clock(clock), .en(advance), .num(s3_ff.ya),
      .den(DEN_W'(s3_ff.cw)), .neg(s3_ff.ny[2]), .quo(qya));
   cpqw_div u_div_yb (.clock(clock), .en(advance), .num(s3_ff.yb),
      .den(DEN_W'(s3_ff.rh)), .neg(s3_ff.ny[1]), .quo(qyb));
   cpqw_div u_div_yab (.clock(clock), .en(advance), .num(s3_ff.yab),
      .den(s3_ff.cwrh), .neg(s3_ff.ny[0]), .quo(qyab));

   always_comb begin
      logic signed [SUM_W-1:0] xs, ys;
      logic                    out_x, out_y;
      side_type                sx, sy;
      sx = dsx_ff[QB-1];
      sy = dsy_ff[QB-1];
      xs = SUM_W'(sx.p1) + SUM_W'(qxa) + SUM_W'(qxb) + SUM_W'(qxab);
      ys = SUM_W'(sy.p1) + SUM_W'(qya) + SUM_W'(qyb) + SUM_W'(qyab);
      out_x = xs[SUM_W-1] || (xs >= $signed(SUM_W'(sx.lim)));
      out_y = ys[SUM_W-1] || (ys >= $signed(SUM_W'(sy.lim)));
      rsp_x_in = '0;
      rsp_y_in = '0;
      if (sx.none) begin
         rsp_st_in = STAT_NONE;
      end else if (out_x || out_y) begin
         rsp_st_in = STAT_FILL;
      end else begin
         rsp_st_in = STAT_FETCH;
         rsp_x_in  = xs[CRD_W-1:0];
         rsp_y_in  = ys[CRD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_ff[QB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_x_ff  <= rsp_x_in;
         rsp_y_ff  <= rsp_y_in;
         rsp_st_ff <= rsp_st_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_src_x  = rsp_x_ff;
   assign rsp_src_y  = rsp_y_ff;
   assign rsp_status = rsp_st_ff;

`ifndef SYNTH
   a_fetch_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FETCH) |-> (!rsp_src_x[CRD_W-1] && !rsp_src_y[CRD_W-1]))
      else $error("fetch beat with negative source coordinate");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_FETCH || rsp_status == STAT_FILL ||
                     rsp_status == STAT_NONE))
      else $error("undefined status code");
   a_zero_when_unused: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_FETCH) |-> (rsp_src_x == '0 && rsp_src_y == '0))
      else $error("source coordinate not cleared for fill or uncovered beat");
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while response is stalled");
`endif

endmodule
